@@ rtl/bben_pkg.sv @@
// ----------------------------------------------------------------------------
// bben_pkg
// Shared constants of the edge-normalised box blur: register indexes, command
// codes and fixed field widths.
// ----------------------------------------------------------------------------
package bben_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_HALF_WINDOW  = 2'd2;
  localparam logic [1:0] CFG_COLOR_MODE   = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CH_W       = 8;
  localparam int SAMPLE_W   = 3 * CH_W;

  // input command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

endpackage

@@ rtl/box_blur_edge_normalized.sv @@
// ----------------------------------------------------------------------------
// box_blur_edge_normalized
// Mean filter over a raster pixel stream with the window clipped at the
// frame edges; samples live in a ring line store.
// ----------------------------------------------------------------------------
// Each accepted transaction inside the frame writes its sample into the line
// store and, once the stream is (g-1)*width+(g-1) positions ahead, produces
// one output pixel. Producing it sweeps the 2g x 2g window through the store
// at one read per cycle through a registered read, then a restoring divider
// takes one quotient bit per cycle over the sum width; no new transaction is
// taken until the pixel has gone to the output register. After the frame,
// flush transactions drain the delayed outputs; the last one carries
// out_frame_done and restarts the frame.
module box_blur_edge_normalized
  import bben_pkg::*;
#(
  parameter int MAX_WIDTH       = 1024,
  parameter int MAX_HEIGHT      = 1024,
  parameter int MAX_HALF_WINDOW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [CH_W-1:0]       in_blue_or_gray,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_red,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       out_blue_or_gray,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_red,
  output logic                  out_frame_done
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int GW    = $clog2(MAX_HALF_WINDOW + 1);
  localparam int DEPTH = 2 * MAX_HALF_WINDOW * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + DEPTH) + 1;
  localparam int CW    = $clog2(4 * MAX_HALF_WINDOW * MAX_HALF_WINDOW + 1);
  localparam int SUM_W = $clog2(4 * MAX_HALF_WINDOW * MAX_HALF_WINDOW * 255 + 1);
  localparam int DCW   = $clog2(SUM_W);
  localparam logic signed [AW+2:0] DEPTH_S = (AW+3)'(DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  // modular add on the ring address
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                              input logic signed [AW+2:0] s);
    logic signed [AW+2:0] t;
    t = $signed({3'b000, a}) + s;
    if (t < 0) begin
      t = t + DEPTH_S;
    end else if (t >= DEPTH_S) begin
      t = t - DEPTH_S;
    end
    return t[AW-1:0];
  endfunction

  // configuration registers
  logic [10:0] frame_width_r, frame_height_r;
  logic [3:0]  half_window_r;
  logic        color_mode_r;

  // control state
  logic [2:0]     state_r;
  logic [PW-1:0]  p_r, q_r;
  logic [WW-1:0]  ox_r;
  logic [HW-1:0]  oy_r;
  logic [AW-1:0]  wptr_r;

  // per output item
  logic                 done_r;
  logic [WW-1:0]        x_r;
  logic [AW-1:0]        a_r;
  logic [GW:0]          cx_r, cy_r;
  logic signed [WW:0]   xx_r;
  logic signed [HW:0]   yy_r;
  logic [DCW-1:0]       div_cnt_r;
  logic                 rd_val_r;
  logic [SAMPLE_W-1:0]  rdata_r;
  logic [SUM_W-1:0]     sum_r [3];
  logic [CW-1:0]        rem_r [3];
  logic [CW-1:0]        cnt_r;

  logic [SAMPLE_W-1:0]  mem [DEPTH];

  // clamped frame geometry
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [GW-1:0]  g_eff;
  logic [PW-1:0]  total, delay;
  logic [GW:0]    two_g_m1;
  logic signed [AW+2:0] offset0, row_step;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_r);
    end
    if (half_window_r == '0) begin
      g_eff = GW'(1);
    end else if (32'(half_window_r) > 32'(MAX_HALF_WINDOW)) begin
      g_eff = GW'(MAX_HALF_WINDOW);
    end else begin
      g_eff = GW'(half_window_r);
    end
  end

  assign total    = PW'(w_eff) * PW'(h_eff);
  assign delay    = PW'(g_eff - GW'(1)) * (PW'(w_eff) + PW'(1));
  assign two_g_m1 = {g_eff, 1'b0} - (GW+1)'(1);
  assign offset0  = (AW+3)'(two_g_m1) * ((AW+3)'(w_eff) + (AW+3)'(1));
  assign row_step = $signed((AW+3)'(w_eff)) - $signed((AW+3)'(two_g_m1));

  // handshake and item decode
  logic accept, in_frame, due, last_out;
  logic [SAMPLE_W-1:0] wdata;
  logic cell_ok, last_col;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_frame = p_r < total;
  assign due      = p_r >= delay;
  assign last_out = (q_r + PW'(1)) >= total;

  always_comb begin
    wdata = '0;
    if (in_command == CMD_PIXEL) begin
      wdata[CH_W-1:0] = in_blue_or_gray;
      if (color_mode_r) begin
        wdata[2*CH_W-1:CH_W]     = in_green;
        wdata[3*CH_W-1:2*CH_W]   = in_red;
      end
    end
  end

  assign cell_ok  = (xx_r >= 0) && (xx_r < $signed({1'b0, w_eff})) &&
                    (yy_r >= 0) && (yy_r < $signed({1'b0, h_eff}));
  assign last_col = (cx_r == two_g_m1);

  // line store
  always_ff @(posedge clk) begin
    if (accept && in_frame) begin
      mem[wptr_r] <= wdata;
    end
    rdata_r <= mem[a_r];
  end

  // configuration, positions and sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 11'd640;
      frame_height_r <= 11'd480;
      half_window_r  <= 4'd1;
      color_mode_r   <= 1'b0;
      state_r        <= ST_IDLE;
      p_r            <= '0;
      q_r            <= '0;
      ox_r           <= '0;
      oy_r           <= '0;
      wptr_r         <= '0;
      rd_val_r       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      rd_val_r <= (state_r == ST_SCAN) && cell_ok;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
          CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
          CFG_HALF_WINDOW:  half_window_r  <= cfg_wdata[3:0];
          CFG_COLOR_MODE:   color_mode_r   <= cfg_wdata[0];
          default: ;
        endcase
        p_r    <= '0;
        q_r    <= '0;
        ox_r   <= '0;
        oy_r   <= '0;
        wptr_r <= '0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            a_r  <= ring_add(wptr_r, -offset0);
            cx_r <= '0;
            cy_r <= '0;
            x_r  <= ox_r;
            xx_r <= $signed({1'b0, ox_r}) - $signed((WW+1)'(g_eff));
            yy_r <= $signed({1'b0, oy_r}) - $signed((HW+1)'(g_eff));
            done_r <= last_out;
            if (due) begin
              state_r <= ST_SCAN;
              if (last_out) begin
                p_r    <= '0;
                q_r    <= '0;
                ox_r   <= '0;
                oy_r   <= '0;
                wptr_r <= '0;
              end else begin
                p_r    <= p_r + PW'(1);
                q_r    <= q_r + PW'(1);
                wptr_r <= ring_add(wptr_r, (AW+3)'(1));
                if (ox_r == w_eff - WW'(1)) begin
                  ox_r <= '0;
                  oy_r <= oy_r + HW'(1);
                end else begin
                  ox_r <= ox_r + WW'(1);
                end
              end
            end else begin
              p_r    <= p_r + PW'(1);
              wptr_r <= ring_add(wptr_r, (AW+3)'(1));
            end
          end
        end
        ST_SCAN: begin
          // step through the window, one cell a cycle
          if (last_col) begin
            cx_r <= '0;
            cy_r <= cy_r + (GW+1)'(1);
            xx_r <= $signed({1'b0, x_r}) - $signed((WW+1)'(g_eff));
            yy_r <= yy_r + (HW+1)'(1);
            a_r  <= ring_add(a_r, row_step);
            if (cy_r == two_g_m1) begin
              state_r <= ST_DRAIN;
            end
          end else begin
            cx_r <= cx_r + (GW+1)'(1);
            xx_r <= xx_r + (WW+1)'(1);
            a_r  <= ring_add(a_r, (AW+3)'(1));
          end
        end
        ST_DRAIN: begin
          div_cnt_r <= '0;
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt_r <= div_cnt_r + DCW'(1);
          if (div_cnt_r == DCW'(SUM_W - 1)) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          // output register, waits while an earlier result is unread
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            out_blue_or_gray <= sum_r[0][CH_W-1:0];
            out_green        <= sum_r[1][CH_W-1:0];
            out_red          <= sum_r[2][CH_W-1:0];
            out_frame_done   <= done_r;
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // window sums, then restoring division in place
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r <= '0;
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= '0;
        rem_r[k] <= '0;
      end
    end else if (rd_val_r) begin
      cnt_r <= cnt_r + CW'(1);
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= sum_r[k] + SUM_W'(rdata_r[k*CH_W +: CH_W]);
      end
    end else if (state_r == ST_DIV) begin
      for (int k = 0; k < 3; k++) begin
        logic [CW:0] rem_sh;
        rem_sh = {rem_r[k], sum_r[k][SUM_W-1]};
        if (rem_sh >= {1'b0, cnt_r}) begin
          rem_r[k] <= CW'(rem_sh - {1'b0, cnt_r});
          sum_r[k] <= {sum_r[k][SUM_W-2:0], 1'b1};
        end else begin
          rem_r[k] <= CW'(rem_sh);
          sum_r[k] <= {sum_r[k][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

@@ rtl/bben_checker.sv @@
// ----------------------------------------------------------------------------
// bben_checker
// Port-level checks of the box blur, bound to the top level.
// ----------------------------------------------------------------------------
module bben_checker
  import bben_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CH_W-1:0] out_blue_or_gray,
  input logic            out_frame_done
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_blue_or_gray) &&
    $stable(out_frame_done))
    else $error("result changed while stalled");

  // a new result only follows a busy cycle
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without window sweep");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind box_blur_edge_normalized bben_checker u_bben_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_blue_or_gray (out_blue_or_gray),
  .out_frame_done   (out_frame_done)
);

@@ bench/box_blur_edge_normalized_tb.sv @@
// ----------------------------------------------------------------------------
// box_blur_edge_normalized_tb
// Self-checking bench for the edge-normalised box blur. Frames, some cut short,
// are streamed under many register settings (clamped extremes included), with
// random gaps on the input side and random stalls on the output side. A
// behavioural copy of the filter predicts every output pixel, and each
// transaction leaving the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module box_blur_edge_normalized_tb;
  import bben_pkg::*;

  localparam int RING_DEPTH = 16384;
  localparam int LIMIT_W    = 1024;
  localparam int LIMIT_H    = 1024;
  localparam int LIMIT_G    = 8;

  typedef struct packed {
    logic            command;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_in_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic            done;
  } mean_pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_command = CMD_PIXEL;
  logic [CH_W-1:0]       in_blue_or_gray = '0;
  logic [CH_W-1:0]       in_green = '0;
  logic [CH_W-1:0]       in_red = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CH_W-1:0]       out_blue_or_gray;
  logic [CH_W-1:0]       out_green;
  logic [CH_W-1:0]       out_red;
  logic                  out_frame_done;

  pixel_in_t   pixel_queue[$];
  mean_pixel_t mean_queue[$];

  // behavioural copy of the filter state
  logic [SAMPLE_W-1:0] sample_ring[RING_DEPTH];
  logic [10:0]         reg_width  = 11'd640;
  logic [10:0]         reg_height = 11'd480;
  logic [3:0]          reg_half   = 4'd1;
  logic                reg_color  = 1'b0;
  int unsigned         stream_pos;
  int unsigned         out_pos;

  int errors;
  int send_idle_pct = 14;
  int recv_idle_pct = 88;

  box_blur_edge_normalized dut (.*);

  always #10 clk = ~clk;

  function automatic int unsigned clamp_val(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // advance the filter copy by one accepted input transaction
  task automatic blur_accept(input pixel_in_t px);
    int unsigned w, h, g, total, delay, p, q, cnt, sb, sg, sr;
    int          y, x, yy, xx;
    logic [SAMPLE_W-1:0] s;
    mean_pixel_t m;
    w = clamp_val(reg_width, LIMIT_W);
    h = clamp_val(reg_height, LIMIT_H);
    g = clamp_val(reg_half, LIMIT_G);
    total = w * h;
    delay = (g - 1) * w + (g - 1);
    p = stream_pos;
    if (p < total) begin
      s = '0;
      if (px.command == CMD_PIXEL) begin
        s[7:0] = px.blue;
        if (reg_color) begin
          s[15:8]  = px.green;
          s[23:16] = px.red;
        end
      end
      sample_ring[p % RING_DEPTH] = s;
    end
    stream_pos = p + 1;
    if (p < delay) return;
    q = out_pos;
    y = q / w;
    x = q % w;
    cnt = 0; sb = 0; sg = 0; sr = 0;
    for (yy = y - int'(g); yy < y + int'(g); yy++) begin
      if (yy < 0 || yy >= int'(h)) continue;
      for (xx = x - int'(g); xx < x + int'(g); xx++) begin
        if (xx < 0 || xx >= int'(w)) continue;
        s = sample_ring[(yy * w + xx) % RING_DEPTH];
        sb += s[7:0];
        sg += s[15:8];
        sr += s[23:16];
        cnt++;
      end
    end
    m.blue  = CH_W'(sb / cnt);
    m.green = reg_color ? CH_W'(sg / cnt) : '0;
    m.red   = reg_color ? CH_W'(sr / cnt) : '0;
    m.done  = (q + 1 >= total);
    if (m.done) begin
      stream_pos = 0;
      out_pos = 0;
    end else begin
      out_pos = q + 1;
    end
    mean_queue.push_back(m);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid        <= 1'b1;
        in_command      <= pixel_queue[0].command;
        in_blue_or_gray <= pixel_queue[0].blue;
        in_green        <= pixel_queue[0].green;
        in_red          <= pixel_queue[0].red;
        void'(pixel_queue.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    mean_pixel_t exp_px;
    if (rst_n) begin
      if (in_valid && in_ready)
        blur_accept({in_command, in_blue_or_gray, in_green, in_red});
      if (out_valid && out_ready) begin
        if (mean_queue.size() == 0) begin
          $display("%0t unexpected output: actual %h %h %h done %b", $time,
                   out_blue_or_gray, out_green, out_red, out_frame_done);
          errors++;
        end else begin
          exp_px = mean_queue.pop_front();
          if ({out_blue_or_gray, out_green, out_red, out_frame_done} != exp_px) begin
            $display("%0t mismatch: expected %h %h %h done %b, actual %h %h %h done %b",
                     $time, exp_px.blue, exp_px.green, exp_px.red, exp_px.done,
                     out_blue_or_gray, out_green, out_red, out_frame_done);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[CFG_DATA_W-1:0];
    case (idx)
      CFG_FRAME_WIDTH:  reg_width  = data[10:0];
      CFG_FRAME_HEIGHT: reg_height = data[10:0];
      CFG_HALF_WINDOW:  reg_half   = data[3:0];
      default:          reg_color  = data[0];
    endcase
    stream_pos = 0;
    out_pos = 0;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait until every transaction has gone through and the block is quiet
  task automatic drain;
    while (pixel_queue.size() > 0 || in_valid) @(posedge clk);
    while (mean_queue.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic push_pixel(input logic cmd, input logic [7:0] b, input logic [7:0] gr,
                            input logic [7:0] r);
    pixel_queue.push_back({cmd, b, gr, r});
  endtask

  // one frame under a fresh setting; cut short for a broken frame
  task automatic blur_frame(input int unsigned w_raw, input int unsigned h_raw,
                            input int unsigned g_raw, input logic color,
                            input bit cut_short);
    int unsigned w, h, g, n;
    write_reg(CFG_FRAME_WIDTH, w_raw);
    write_reg(CFG_FRAME_HEIGHT, h_raw);
    write_reg(CFG_HALF_WINDOW, g_raw);
    write_reg(CFG_COLOR_MODE, color);
    w = clamp_val(w_raw, LIMIT_W);
    h = clamp_val(h_raw, LIMIT_H);
    g = clamp_val(g_raw, LIMIT_G);
    n = w * h + (g - 1) * w + (g - 1);
    if (cut_short) n = $urandom_range(n);
    for (int unsigned i = 0; i < n; i++) begin
      // mostly pixels, some flushes spread through the stream
      push_pixel(($urandom_range(15) == 0) ? CMD_FLUSH : CMD_PIXEL,
                 CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    end
    drain();
  endtask

  initial begin
    int sent;
    int unsigned w, h, g;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 2x2 colour frame, window one, extremes and flushes
    write_reg(CFG_FRAME_WIDTH, 2);
    write_reg(CFG_FRAME_HEIGHT, 2);
    write_reg(CFG_HALF_WINDOW, 1);
    write_reg(CFG_COLOR_MODE, 1);
    push_pixel(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
    push_pixel(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(CMD_PIXEL, 8'hAA, 8'h55, 8'h0F);
    // a second frame follows straight after the frame end
    push_pixel(CMD_PIXEL, 8'h01, 8'h80, 8'hFE);
    push_pixel(CMD_PIXEL, 8'hFF, 8'h7F, 8'h00);
    push_pixel(CMD_PIXEL, 8'h00, 8'hFF, 8'h80);
    push_pixel(CMD_PIXEL, 8'h33, 8'hCC, 8'h11);
    drain();
    // gray 3x3 with a window of two: samples past the frame act as flushes
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 3);
    write_reg(CFG_HALF_WINDOW, 2);
    write_reg(CFG_COLOR_MODE, 0);
    for (int i = 0; i < 13; i++)
      push_pixel((i >= 9) ? CMD_PIXEL : CMD_PIXEL, (i % 2) ? 8'hFF : 8'h00, 8'hFF, 8'hFF);
    drain();

    // random frames in three idling phases
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 14 : 0;
      // register extremes, out-of-range values clamp
      case (phase)
        0: begin
          blur_frame(0, 0, 0, 1, 0);
          blur_frame(5, 4, 15, 0, 0);
          sent += 1 + 62;
        end
        1: begin
          blur_frame(4, 3, 8, 1, 0);
          sent += 47;
        end
        default: begin
          blur_frame(2047, 1, 1, 0, 0);
          sent += 1024;
        end
      endcase
      while (sent < (phase + 1) * 200) begin
        w = $urandom_range(12, 1);
        h = $urandom_range(8, 1);
        g = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
        sent += w * h + (g - 1) * w + (g - 1);
        blur_frame(w, h, g, $urandom_range(1), $urandom_range(9) == 0);
      end
    end

    drain();
    if (errors == 0) begin
      $display("PASS box_blur_edge_normalized");
    end else begin
      $display("FAIL box_blur_edge_normalized");
    end
    $finish;
  end

  // run limit
  initial begin
    #60000000;
    $display("FAIL box_blur_edge_normalized");
    $finish;
  end

endmodule
